// ----- design/smro_pkg.sv -----
// ----------------------------------------------------------------------------
// smro_pkg
// Types, constants and arithmetic helpers shared by the rotor observer files.
// ----------------------------------------------------------------------------
package smro_pkg;

    // Serial multiplier operand widths: A is a signed data word, B a signed
    // coefficient wide enough for every register as two's complement.
    localparam int MUL_AW = 40;
    localparam int MUL_BW = 33;
    localparam int MUL_CW = $clog2(MUL_BW);

    localparam int ATAN_LEN = 24;

    localparam logic [2:0] REG_DECAY  = 3'd0;
    localparam logic [2:0] REG_INGAIN = 3'd1;
    localparam logic [2:0] REG_SWITCH = 3'd2;
    localparam logic [2:0] REG_EMFGN  = 3'd3;
    localparam logic [2:0] REG_B0     = 3'd4;
    localparam logic [2:0] REG_A1     = 3'd5;
    localparam logic [2:0] REG_A2     = 3'd6;

    typedef struct packed {
        logic signed [15:0] voltage_alpha;
        logic signed [15:0] voltage_beta;
        logic signed [15:0] current_alpha;
        logic signed [15:0] current_beta;
    } in_t;

    typedef struct packed {
        logic        [15:0] electrical_angle;
        logic signed [31:0] electrical_speed;
        logic signed [15:0] emf_alpha;
        logic signed [15:0] emf_beta;
    } out_t;

    typedef enum logic [2:0] {
        OP_EST_DECAY,
        OP_EST_DRIVE,
        OP_RES_DECAY,
        OP_EMF_CORR,
        OP_FF,
        OP_FB1,
        OP_FB2
    } op_t;

    // Arctangent of 2^-i in binary turns, 2^32 equals one turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41721;
            5'd15:   v = 32'd20860;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2607;
            5'd19:   v = 32'd1303;
            5'd20:   v = 32'd651;
            5'd21:   v = 32'd325;
            5'd22:   v = 32'd162;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Add half an LSB, then arithmetic shift right.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                       input int unsigned s);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Switching term eta * sign(x) * 2^15.
    function automatic logic signed [63:0] switch_term(input logic [15:0] eta,
                                                       input logic signed [31:0] x);
        logic signed [63:0] m;
        m = $signed({33'd0, eta, 15'd0});
        if (x > 32'sd0)
            return m;
        else if (x < 32'sd0)
            return -m;
        else
            return 64'sd0;
    endfunction

endpackage

// ----- design/smro_mul.sv -----
// ----------------------------------------------------------------------------
// smro_mul
// Bit-serial signed multiplier: one coefficient bit per cycle, shift-add.
// ----------------------------------------------------------------------------
module smro_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [smro_pkg::MUL_AW-1:0]     op_a,
    input  logic signed [smro_pkg::MUL_BW-1:0]     op_b,
    output logic                                   done,
    output logic signed [63:0]                     product
);
    import smro_pkg::*;

    logic signed [MUL_AW:0]   hi_reg;
    logic        [MUL_BW-1:0] lo_reg;
    logic signed [MUL_AW:0]   a_reg;
    logic        [MUL_CW-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [MUL_AW:0] addend;
    logic signed [MUL_AW:0] sum;
    logic                   last;
    logic [MUL_AW+MUL_BW:0] full_w;

    assign last = (cnt_reg == MUL_CW'(MUL_BW - 1));

    // The top coefficient bit carries negative weight.
    always_comb
    begin
        if (!lo_reg[0])
            addend = '0;
        else if (last)
            addend = -a_reg;
        else
            addend = a_reg;
        sum = hi_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= {op_a[MUL_AW-1], op_a};
            hi_reg <= '0;
            lo_reg <= op_b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[MUL_AW], sum[MUL_AW:1]};
            lo_reg <= {sum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    // Every product the observer forms fits in 64 bits.
    assign full_w  = {hi_reg, lo_reg};
    assign done    = done_reg;
    assign product = $signed(full_w[63:0]);

endmodule

// ----- design/sliding_mode_rotor_observer.sv -----
// ----------------------------------------------------------------------------
// sliding_mode_rotor_observer
// Sliding-mode back-EMF observer giving rotor angle and speed per sample.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one item of alpha and
// beta voltage and measured current. The output channel (out_valid,
// out_stall, out_data) returns one item per input: angle, filtered speed and
// both EMF estimates. Coefficients are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this. All products go through one bit-serial
// multiplier; each item takes eleven products plus the CORDIC rotation (one
// step per cycle, min(CORDIC_STEPS, ATAN_LEN) steps, none for a zero EMF).
// One item is processed at a time; a new item waits until the last is done.
// in_stall is high from acceptance until the result has been handed to the
// output register. A result waits in that register while out_stall is high;
// a finished computation holds until the register is free.
// Reset clears all coefficients, observer state and filter history to zero.
// ----------------------------------------------------------------------------
module sliding_mode_rotor_observer #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  smro_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output smro_pkg::out_t   out_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import smro_pkg::*;

    localparam int ROT_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int OUT_BITS  = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
    localparam logic signed [31:0] EMF_HI = (32'sd1 <<< (OUT_BITS - 1)) - 32'sd1;
    localparam logic signed [31:0] EMF_LO = -EMF_HI - 32'sd1;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PREP     = 7'b0000010,
        ST_MUL      = 7'b0000100,
        ST_ROT_INIT = 7'b0001000,
        ST_ROT      = 7'b0010000,
        ST_DIR      = 7'b0100000,
        ST_FIN      = 7'b1000000
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   axis_reg;
    logic   launch_reg;

    logic [14:0]        decay_reg;
    logic [15:0]        ingain_reg;
    logic [15:0]        switch_reg;
    logic [23:0]        emfgain_reg;
    logic signed [31:0] b0_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] a2_reg;

    logic signed [31:0] est_reg [2];
    logic signed [31:0] emf_reg [2];
    logic signed [31:0] rp_reg  [2];
    logic        [15:0] last_dir_reg;
    logic signed [15:0] x1_reg;
    logic signed [15:0] x2_reg;
    logic signed [31:0] y1_reg;
    logic signed [31:0] y2_reg;

    in_t                in_reg;
    logic signed [31:0] r_reg;
    logic signed [63:0] acc_reg;
    logic signed [MUL_AW-1:0] inner_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic        [31:0] ang_reg;
    logic        [4:0]  rot_idx_reg;
    logic               zero_reg;
    logic        [15:0] dir_reg;
    logic signed [15:0] delta_reg;
    out_t               res_reg;
    out_t               out_reg;
    logic               out_valid_reg;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic                     mul_done;
    logic signed [63:0]       mul_p;

    logic signed [15:0] u_cur;
    logic signed [15:0] meas_cur;
    logic signed [31:0] est_cur;
    logic signed [31:0] emf_cur;
    logic signed [31:0] rp_cur;
    logic signed [63:0] r_wide;
    logic signed [63:0] drive_acc;
    logic signed [63:0] inner_val;
    logic signed [63:0] emf_sum;
    logic signed [63:0] y_val;
    logic signed [31:0] speed;
    logic        [15:0] dir_w;
    logic        [15:0] angle_w;
    logic signed [35:0] cdx;
    logic signed [35:0] cdy;
    logic               out_free;

    assign u_cur    = axis_reg ? in_reg.voltage_beta : in_reg.voltage_alpha;
    assign meas_cur = axis_reg ? in_reg.current_beta : in_reg.current_alpha;
    assign est_cur  = est_reg[axis_reg];
    assign emf_cur  = emf_reg[axis_reg];
    assign rp_cur   = rp_reg[axis_reg];

    always_comb
    begin
        case (op_reg)
            OP_EST_DECAY:
            begin
                mul_a = MUL_AW'(est_cur);
                mul_b = {18'd0, decay_reg};
            end
            OP_EST_DRIVE:
            begin
                mul_a = MUL_AW'(u_cur) - MUL_AW'(emf_cur);
                mul_b = {17'd0, ingain_reg};
            end
            OP_RES_DECAY:
            begin
                mul_a = MUL_AW'(rp_cur);
                mul_b = {18'd0, decay_reg};
            end
            OP_EMF_CORR:
            begin
                mul_a = inner_reg;
                mul_b = {9'd0, emfgain_reg};
            end
            OP_FF:
            begin
                mul_a = MUL_AW'(delta_reg) + (MUL_AW'(x1_reg) <<< 1) + MUL_AW'(x2_reg);
                mul_b = {b0_reg[31], b0_reg};
            end
            OP_FB1:
            begin
                mul_a = MUL_AW'(y1_reg);
                mul_b = {a1_reg[31], a1_reg};
            end
            OP_FB2:
            begin
                mul_a = MUL_AW'(y2_reg);
                mul_b = {a2_reg[31], a2_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    smro_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (launch_reg),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb
    begin
        r_wide    = 64'(est_cur) - 64'(meas_cur);
        drive_acc = acc_reg + mul_p - switch_term(switch_reg, r_reg);
        inner_val = round_shift((64'(r_reg) <<< 16) - (mul_p <<< 1)
                                + switch_term(switch_reg, rp_cur), 16);
        emf_sum   = 64'(emf_cur) + round_shift(mul_p, 16);
        y_val     = acc_reg - round_shift(mul_p, 30);
        speed     = sat32(y_val);
        dir_w     = zero_reg ? 16'd0 : 16'((ang_reg + 32'h8000) >> 16);
        if (speed > 32'sd0)
            angle_w = dir_reg - 16'h4000;
        else if (speed < 32'sd0)
            angle_w = dir_reg - 16'hc000;
        else
            angle_w = dir_reg;
        cdx = cy_reg >>> rot_idx_reg;
        cdy = cx_reg >>> rot_idx_reg;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= '0;
            ingain_reg  <= '0;
            switch_reg  <= '0;
            emfgain_reg <= '0;
            b0_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DECAY:  decay_reg   <= cfg_data[14:0];
                REG_INGAIN: ingain_reg  <= cfg_data[15:0];
                REG_SWITCH: switch_reg  <= cfg_data[15:0];
                REG_EMFGN:  emfgain_reg <= cfg_data[23:0];
                REG_B0:     b0_reg      <= cfg_data;
                REG_A1:     a1_reg      <= cfg_data;
                REG_A2:     a2_reg      <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer and observer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_EST_DECAY;
            axis_reg      <= 1'b0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            est_reg[0]    <= '0;
            est_reg[1]    <= '0;
            emf_reg[0]    <= '0;
            emf_reg[1]    <= '0;
            rp_reg[0]     <= '0;
            rp_reg[1]     <= '0;
            last_dir_reg  <= '0;
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
        end
        else
        begin
            // Every product except the last one of an axis and of the filter
            // starts the next product right away.
            launch_reg <= (state_reg == ST_PREP) || (state_reg == ST_DIR) ||
                          (state_reg == ST_MUL && mul_done &&
                           op_reg != OP_EMF_CORR && op_reg != OP_FB2);

            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    op_reg    <= OP_EST_DECAY;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        case (op_reg)
                            OP_EST_DECAY:
                                op_reg <= OP_EST_DRIVE;
                            OP_EST_DRIVE:
                            begin
                                est_reg[axis_reg] <= sat32(round_shift(drive_acc, 16));
                                op_reg            <= OP_RES_DECAY;
                            end
                            OP_RES_DECAY:
                                op_reg <= OP_EMF_CORR;
                            OP_EMF_CORR:
                            begin
                                emf_reg[axis_reg] <= sat32(emf_sum);
                                rp_reg[axis_reg]  <= r_reg;
                                if (!axis_reg)
                                begin
                                    axis_reg  <= 1'b1;
                                    state_reg <= ST_PREP;
                                end
                                else
                                    state_reg <= ST_ROT_INIT;
                            end
                            OP_FF:
                                op_reg <= OP_FB1;
                            OP_FB1:
                                op_reg <= OP_FB2;
                            OP_FB2:
                            begin
                                x2_reg       <= x1_reg;
                                x1_reg       <= delta_reg;
                                y2_reg       <= y1_reg;
                                y1_reg       <= speed;
                                last_dir_reg <= dir_reg;
                                state_reg    <= ST_FIN;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_ROT_INIT:
                begin
                    // With the EMF at the origin the direction is zero and no
                    // rotation is needed.
                    if (zero_reg)
                        state_reg <= ST_DIR;
                    else
                        state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (rot_idx_reg == 5'(ROT_STEPS - 1))
                        state_reg <= ST_DIR;
                end
                ST_DIR:
                begin
                    op_reg    <= OP_FF;
                    state_reg <= ST_MUL;
                end
                ST_FIN:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            in_reg <= in_data;
        if (state_reg == ST_PREP)
            r_reg <= sat32(r_wide);
        if (state_reg == ST_MUL && mul_done)
        begin
            case (op_reg)
                OP_EST_DECAY: acc_reg   <= mul_p <<< 1;
                OP_RES_DECAY: inner_reg <= inner_val[MUL_AW-1:0];
                OP_FF:        acc_reg   <= round_shift(mul_p, 16);
                OP_FB1:       acc_reg   <= y_val;
                OP_FB2:
                begin
                    res_reg.electrical_angle <= angle_w;
                    res_reg.electrical_speed <= speed;
                    res_reg.emf_alpha <= (emf_reg[0] > EMF_HI) ? EMF_HI[15:0] :
                                         (emf_reg[0] < EMF_LO) ? EMF_LO[15:0] :
                                         emf_reg[0][15:0];
                    res_reg.emf_beta  <= (emf_reg[1] > EMF_HI) ? EMF_HI[15:0] :
                                         (emf_reg[1] < EMF_LO) ? EMF_LO[15:0] :
                                         emf_reg[1][15:0];
                end
                default: ;
            endcase
        end
        if (state_reg == ST_MUL && mul_done && op_reg == OP_EMF_CORR && axis_reg)
        begin
            // emf_reg[1] is written at this same edge; start from the new beta
            // value here and the stored alpha value.
            zero_reg    <= (emf_reg[0] == 32'sd0) && (sat32(emf_sum) == 32'sd0);
            rot_idx_reg <= '0;
            if (emf_reg[0] < 32'sd0)
            begin
                cx_reg  <= -36'(emf_reg[0]);
                cy_reg  <= -36'(sat32(emf_sum));
                ang_reg <= 32'h8000_0000;
            end
            else
            begin
                cx_reg  <= 36'(emf_reg[0]);
                cy_reg  <= 36'(sat32(emf_sum));
                ang_reg <= 32'd0;
            end
        end
        if (state_reg == ST_ROT)
        begin
            rot_idx_reg <= rot_idx_reg + 1'b1;
            if (cy_reg >= 36'sd0)
            begin
                cx_reg  <= cx_reg + cdx;
                cy_reg  <= cy_reg - cdy;
                ang_reg <= ang_reg + atan_turn(rot_idx_reg);
            end
            else
            begin
                cx_reg  <= cx_reg - cdx;
                cy_reg  <= cy_reg + cdy;
                ang_reg <= ang_reg - atan_turn(rot_idx_reg);
            end
        end
        if (state_reg == ST_DIR)
        begin
            dir_reg   <= dir_w;
            delta_reg <= $signed(dir_w - last_dir_reg);
        end
        if (state_reg == ST_FIN && out_free)
            out_reg <= res_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_done_in_mul : assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside a multiply step");

    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == ST_PREP && !axis_reg)
        else $error("accepted item did not start on the alpha axis");

    a_rot_bound : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> rot_idx_reg < 5'(ROT_STEPS))
        else $error("rotation step count exceeded");

    a_out_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("result presented without finishing an item");

endmodule

// ----- tb/observer_checker.sv -----
// ----------------------------------------------------------------------------
// observer_checker
// Watches the rotor observer's channels and configuration writes, predicts
// each result from its own copy of the coefficients and observer state, and
// compares every returned item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module observer_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  smro_pkg::in_t    in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  smro_pkg::out_t   out_data,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import smro_pkg::*;

    localparam int EMF_BITS = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;

    localparam logic [31:0] ARCTAN [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    logic [14:0]        decay;
    logic [15:0]        drive_gain;
    logic [15:0]        eta;
    logic [23:0]        emf_k;
    logic signed [31:0] b0, a1, a2;

    longint             cur_est [2];
    longint             emf_est [2];
    longint             res_prev [2];
    logic [15:0]        last_dir;
    longint             fx1, fx2, fy1, fy2;

    out_t               predicted_outputs [$];

    function automatic longint rnd(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint x, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic longint sgn(input longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    // Vectoring CORDIC on the EMF pair; the first half turn is folded in
    // before rotating so the loop only covers the right half plane.
    function automatic logic [15:0] heading(input longint ex, input longint ey);
        longint      x, y, dx, dy;
        logic [31:0] ang;
        logic [31:0] t;
        x = ex;
        y = ey;
        ang = 32'd0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                ang += ARCTAN[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                ang -= ARCTAN[i];
            end
        end
        t = ang + 32'h8000;
        return t[31:16];
    endfunction

    task automatic advance_observer(input in_t d, output out_t res);
        longint             u, m, r, acc, inner, corr, delta, ff, y, spd, ea, eb;
        logic signed [15:0] dd;
        logic [15:0]        dir, offset;
        for (int k = 0; k < 2; k++)
        begin
            u = (k == 0) ? longint'(d.voltage_alpha) : longint'(d.voltage_beta);
            m = (k == 0) ? longint'(d.current_alpha) : longint'(d.current_beta);
            r = clip(cur_est[k] - m, 32);
            acc = longint'(decay) * cur_est[k] * 2 + longint'(drive_gain) * (u - emf_est[k])
                - longint'(eta) * sgn(r) * 32768;
            cur_est[k] = clip(rnd(acc, 16), 32);
            inner = r * 65536 - longint'(decay) * res_prev[k] * 2
                  + longint'(eta) * sgn(res_prev[k]) * 32768;
            inner = rnd(inner, 16);
            corr = rnd(inner * longint'(emf_k), 16);
            emf_est[k] = clip(emf_est[k] + corr, 32);
            res_prev[k] = r;
        end
        dir = heading(emf_est[0], emf_est[1]);
        dd = dir - last_dir;
        delta = dd;
        ff = rnd(longint'(b0) * (delta + 2 * fx1 + fx2), 16);
        y = ff - rnd(longint'(a1) * fy1, 30) - rnd(longint'(a2) * fy2, 30);
        spd = clip(y, 32);
        fx2 = fx1;
        fx1 = delta;
        fy2 = fy1;
        fy1 = spd;
        last_dir = dir;
        offset = (spd > 0) ? 16'h4000 : ((spd < 0) ? 16'hC000 : 16'h0000);
        ea = clip(emf_est[0], EMF_BITS);
        eb = clip(emf_est[1], EMF_BITS);
        res.electrical_angle = dir - offset;
        res.electrical_speed = spd[31:0];
        res.emf_alpha = ea[15:0];
        res.emf_beta = eb[15:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_item;
        out_t new_item;
        if (!rst_n)
        begin
            decay = '0;
            drive_gain = '0;
            eta = '0;
            emf_k = '0;
            b0 = '0;
            a1 = '0;
            a2 = '0;
            for (int k = 0; k < 2; k++)
            begin
                cur_est[k] = 0;
                emf_est[k] = 0;
                res_prev[k] = 0;
            end
            last_dir = '0;
            fx1 = 0;
            fx2 = 0;
            fy1 = 0;
            fy2 = 0;
            predicted_outputs.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DECAY:  decay = cfg_data[14:0];
                    REG_INGAIN: drive_gain = cfg_data[15:0];
                    REG_SWITCH: eta = cfg_data[15:0];
                    REG_EMFGN:  emf_k = cfg_data[23:0];
                    REG_B0:     b0 = cfg_data;
                    REG_A1:     a1 = cfg_data;
                    REG_A2:     a2 = cfg_data;
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected item angle=%h speed=%h emf=%h/%h",
                                 $realtime, out_data.electrical_angle,
                                 out_data.electrical_speed, out_data.emf_alpha,
                                 out_data.emf_beta);
                end
                else
                begin
                    exp_item = predicted_outputs.pop_front();
                    if (out_data.electrical_angle !== exp_item.electrical_angle ||
                        out_data.electrical_speed !== exp_item.electrical_speed ||
                        out_data.emf_alpha !== exp_item.emf_alpha ||
                        out_data.emf_beta !== exp_item.emf_beta)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: exp/act angle %h/%h speed %h/%h emf %h/%h %h/%h",
                                     $realtime,
                                     exp_item.electrical_angle, out_data.electrical_angle,
                                     exp_item.electrical_speed, out_data.electrical_speed,
                                     exp_item.emf_alpha, out_data.emf_alpha,
                                     exp_item.emf_beta, out_data.emf_beta);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_observer(in_data, new_item);
                predicted_outputs.push_back(new_item);
            end
            pending = predicted_outputs.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the rotor observer with directed and random samples under several
// coefficient sets, with random gaps and output stalls; the checker beside
// the block predicts and compares every returned item.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smro_pkg::*;

    localparam int          QUIET_LIMIT = 20000;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    logic        in_took;
    logic        calm;
    int          quiet_cycles;
    int          va, vb, ia, ib;

    sliding_mode_rotor_observer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    observer_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Handshakes are registered here so the stimulus, which runs on the falling
    // edge, reads them away from the rising edge.
    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 15);
    end

    task automatic write_coeffs(input logic [31:0] dk, input logic [31:0] gk,
                                input logic [31:0] ek, input logic [31:0] mk,
                                input logic [31:0] fb0, input logic [31:0] fa1,
                                input logic [31:0] fa2);
        logic [31:0] vals [7];
        vals = '{dk, gk, ek, mk, fb0, fa1, fa2};
        cfg_we <= 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input in_t d);
        if (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do
            @(negedge clk);
        while (!in_took);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic int walk(input int v, input int stepv);
        int n;
        n = v + $signed($urandom_range(2 * stepv)) - stepv;
        if (n > 32767)
            n = 32767;
        if (n < -32768)
            n = -32768;
        return n;
    endfunction

    // Mostly slowly moving motor-like samples, with full-range noise mixed in.
    function automatic in_t motor_sample();
        in_t d;
        if ($urandom_range(99) < 25)
            return in_t'({$urandom, $urandom});
        va = walk(va, 2000);
        vb = walk(vb, 2000);
        ia = walk(ia, 600);
        ib = walk(ib, 600);
        d.voltage_alpha = 16'(va);
        d.voltage_beta = 16'(vb);
        d.current_alpha = 16'(ia);
        d.current_beta = 16'(ib);
        return d;
    endfunction

    initial
    begin
        in_t         d;
        logic [15:0] edges [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        va = 0;
        vb = 0;
        ia = 0;
        ib = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset coefficients: zero residual sign and EMF at the origin.
        send_sample('0);
        send_sample(in_t'({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}));
        wait_drained();

        write_coeffs(32'd31000, 32'd3000, 32'd800, 32'h00020000,
                     32'h00000100, -32'sd1932735283, 32'sd869730877);
        cfg_we <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data <= 32'hffffffff;
        @(negedge clk);
        cfg_we <= 1'b0;
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        for (int i = 0; i < 20; i++)
        begin
            d.voltage_alpha = edges[i % 4];
            d.voltage_beta = edges[(i / 4) % 4];
            d.current_alpha = edges[(i + 1) % 4];
            d.current_beta = edges[(i / 2) % 4];
            send_sample(d);
        end
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_coeffs(32'd30000, 32'd2500, 32'd1200, 32'h00040000,
                                32'h00001000, -32'sd2013265920, 32'sd943718400);
                1: write_coeffs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                2: write_coeffs(32'd0, 32'd0, 32'd0, 32'h00ffffff,
                                32'h80000000, 32'h80000000, 32'h80000000);
                default: write_coeffs($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom);
            endcase
            calm = (p == 2);
            for (int i = 0; i < 250; i++)
            begin
                send_sample(motor_sample());
                if (p == 0 && i == 100)
                    wait_drained();
            end
            calm = 1'b0;
            wait_drained();
        end

        repeat (500) @(negedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
design/smro_pkg.sv
design/smro_mul.sv
design/sliding_mode_rotor_observer.sv
tb/observer_checker.sv
tb/testbench.sv
